@@ sv/mpt_pkg.sv @@
// Shared types, codes and reset constants of the mouse pointer tracker.
package mpt_pkg;

    localparam int BUTTON_COUNT_DEF = 5;
    localparam int BUTTON_BITS      = 5;

    typedef enum logic [1:0] {
        OP_REPORT   = 2'd0,
        OP_SET_POS  = 2'd1,
        OP_RECENTER = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        CFG_ACCEL_EN  = 3'd0,
        CFG_ACCEL_THR = 3'd1,
        CFG_MIN_X     = 3'd2,
        CFG_MAX_X     = 3'd3,
        CFG_MIN_Y     = 3'd4,
        CFG_MAX_Y     = 3'd5
    } t_cfg_idx;

    localparam logic EV_BUTTON = 1'b0;
    localparam logic EV_MOTION = 1'b1;

    localparam logic               ACCEL_EN_RST  = 1'b1;
    localparam logic [14:0]        ACCEL_THR_RST = 15'd10;
    localparam logic signed [15:0] MIN_X_RST     = 16'sd0;
    localparam logic signed [15:0] MAX_X_RST     = 16'sd1023;
    localparam logic signed [15:0] MIN_Y_RST     = 16'sd0;
    localparam logic signed [15:0] MAX_Y_RST     = 16'sd767;
    localparam logic signed [15:0] CURSOR_X_RST  = 16'sd512;
    localparam logic signed [15:0] CURSOR_Y_RST  = 16'sd384;

    typedef struct packed {
        logic               accel_en;
        logic [14:0]        accel_thr;
        logic signed [15:0] min_x;
        logic signed [15:0] max_x;
        logic signed [15:0] min_y;
        logic signed [15:0] max_y;
    } t_cfg;

    // Everything needed to emit all results of one item.
    typedef struct packed {
        logic [BUTTON_BITS-1:0] changed;
        logic [BUTTON_BITS-1:0] buttons;
        logic signed [16:0]     move_x;
        logic signed [16:0]     move_y;
        logic signed [7:0]      wheel;
        logic signed [15:0]     old_x;
        logic signed [15:0]     old_y;
        logic signed [15:0]     new_x;
        logic signed [15:0]     new_y;
    } t_bundle;

endpackage

@@ sv/mouse_pointer_tracker.sv @@
// An accepted item waits in the input register until the result register has space.
// An item gives one result per cycle unless stalled: a report with n changed buttons
// gives n + 1 results, other operations one; the result register sets this pace.
// A new item is taken every cycle, unless stalled, while each item yields a single result.
// Synchronous active-low reset clears the cursor to 512/384, the buttons and
// the pipeline, and loads the configuration defaults.
module mouse_pointer_tracker #(
    parameter int P_BUTTON_COUNT = mpt_pkg::BUTTON_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_operation,
    input  logic [4:0]           i_buttons,
    input  logic signed [15:0]   i_delta_x,
    input  logic signed [15:0]   i_delta_y,
    input  logic signed [7:0]    i_wheel,
    input  logic signed [15:0]   i_new_x,
    input  logic signed [15:0]   i_new_y,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_event_kind,
    output logic [2:0]           o_button_number,
    output logic                 o_pressed,
    output logic [4:0]           o_held_buttons,
    output logic signed [16:0]   o_move_x,
    output logic signed [16:0]   o_move_y,
    output logic signed [7:0]    o_wheel_out,
    output logic signed [15:0]   o_pointer_x,
    output logic signed [15:0]   o_pointer_y,
    output logic                 o_last
);
    import mpt_pkg::*;

    t_cfg    r_cfg;
    t_bundle bun;
    logic    bun_valid;
    logic    space;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_en  <= ACCEL_EN_RST;
            r_cfg.accel_thr <= ACCEL_THR_RST;
            r_cfg.min_x     <= MIN_X_RST;
            r_cfg.max_x     <= MAX_X_RST;
            r_cfg.min_y     <= MIN_Y_RST;
            r_cfg.max_y     <= MAX_Y_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ACCEL_EN:  r_cfg.accel_en  <= i_cfg_data[0];
                CFG_ACCEL_THR: r_cfg.accel_thr <= i_cfg_data[14:0];
                CFG_MIN_X:     r_cfg.min_x     <= i_cfg_data;
                CFG_MAX_X:     r_cfg.max_x     <= i_cfg_data;
                CFG_MIN_Y:     r_cfg.min_y     <= i_cfg_data;
                CFG_MAX_Y:     r_cfg.max_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mpt_calc #(
        .P_BUTTON_COUNT (P_BUTTON_COUNT)
    ) u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_buttons   (i_buttons),
        .i_delta_x   (i_delta_x),
        .i_delta_y   (i_delta_y),
        .i_wheel     (i_wheel),
        .i_new_x     (i_new_x),
        .i_new_y     (i_new_y),
        .i_space     (space),
        .o_bun_valid (bun_valid),
        .o_bun       (bun)
    );

    mpt_emit #(
        .P_BUTTON_COUNT (P_BUTTON_COUNT)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_bun_valid     (bun_valid),
        .i_bun           (bun),
        .o_space         (space),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_button_number (o_button_number),
        .o_pressed       (o_pressed),
        .o_held_buttons  (o_held_buttons),
        .o_move_x        (o_move_x),
        .o_move_y        (o_move_y),
        .o_wheel_out     (o_wheel_out),
        .o_pointer_x     (o_pointer_x),
        .o_pointer_y     (o_pointer_y),
        .o_last          (o_last)
    );

endmodule

@@ sv/mpt_calc.sv @@
// Input register, cursor and button state, and the single-pass update of one item.
module mpt_calc #(
    parameter int P_BUTTON_COUNT = mpt_pkg::BUTTON_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mpt_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_operation,
    input  logic [4:0]           i_buttons,
    input  logic signed [15:0]   i_delta_x,
    input  logic signed [15:0]   i_delta_y,
    input  logic signed [7:0]    i_wheel,
    input  logic signed [15:0]   i_new_x,
    input  logic signed [15:0]   i_new_y,
    input  logic                 i_space,
    output logic                 o_bun_valid,
    output mpt_pkg::t_bundle     o_bun
);
    import mpt_pkg::*;

    localparam int LP_EV = (P_BUTTON_COUNT < BUTTON_BITS) ? P_BUTTON_COUNT : BUTTON_BITS;
    localparam logic [BUTTON_BITS-1:0] LP_EV_MASK = BUTTON_BITS'((1 << LP_EV) - 1);

    function automatic logic signed [16:0] f_accel(input logic signed [15:0] d,
                                                   input logic en,
                                                   input logic [14:0] thr);
        logic signed [16:0] dx;
        logic signed [16:0] half;
        logic [16:0]        mag;
        dx   = 17'(d);
        mag  = dx[16] ? 17'(-dx) : 17'(dx);
        // Halving rounds toward zero, so negative values get one added first.
        half = $signed(dx + $signed({16'd0, dx[16]})) >>> 1;
        return (en && (mag > {2'b00, thr})) ? dx + half : dx;
    endfunction

    function automatic logic signed [15:0] f_clamp(input logic signed [17:0] v,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
        logic signed [17:0] t;
        t = v;
        if (t < 18'(lo)) t = 18'(lo);
        if (t > 18'(hi)) t = 18'(hi);
        return 16'(t);
    endfunction

    function automatic logic signed [15:0] f_mid(input logic signed [15:0] lo,
                                                 input logic signed [15:0] hi);
        logic signed [16:0] s;
        logic signed [16:0] h;
        s = 17'(lo) + 17'(hi);
        h = $signed(s + $signed({16'd0, s[16]})) >>> 1;
        return 16'(h);
    endfunction

    logic                 r_in_valid;
    logic [1:0]           r_op;
    logic [4:0]           r_buttons;
    logic signed [15:0]   r_dx, r_dy, r_nx, r_ny;
    logic signed [7:0]    r_wheel;
    logic signed [15:0]   r_cur_x, r_cur_y;
    logic [4:0]           r_held;

    logic                 op_ok;
    logic                 adv;
    logic                 load;
    logic signed [16:0]   acc_x, acc_y;
    logic signed [15:0]   n_cur_x, n_cur_y;
    logic [4:0]           n_held;
    t_bundle              bun;

    assign acc_x = f_accel(r_dx, i_cfg.accel_en, i_cfg.accel_thr);
    assign acc_y = f_accel(r_dy, i_cfg.accel_en, i_cfg.accel_thr);

    always_comb begin
        op_ok       = 1'b1;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_held      = r_held;
        bun.changed = '0;
        bun.buttons = r_held;
        bun.move_x  = '0;
        bun.move_y  = '0;
        bun.wheel   = '0;
        bun.old_x   = r_cur_x;
        bun.old_y   = r_cur_y;
        case (t_op'(r_op))
            OP_REPORT: begin
                n_cur_x     = f_clamp(18'(r_cur_x) + 18'(acc_x), i_cfg.min_x, i_cfg.max_x);
                n_cur_y     = f_clamp(18'(r_cur_y) + 18'(acc_y), i_cfg.min_y, i_cfg.max_y);
                n_held      = r_buttons;
                bun.changed = (r_held ^ r_buttons) & LP_EV_MASK;
                bun.buttons = r_buttons;
                bun.move_x  = acc_x;
                bun.move_y  = acc_y;
                bun.wheel   = r_wheel;
            end
            OP_SET_POS: begin
                n_cur_x = f_clamp(18'(r_nx), i_cfg.min_x, i_cfg.max_x);
                n_cur_y = f_clamp(18'(r_ny), i_cfg.min_y, i_cfg.max_y);
            end
            OP_RECENTER: begin
                n_cur_x = f_mid(i_cfg.min_x, i_cfg.max_x);
                n_cur_y = f_mid(i_cfg.min_y, i_cfg.max_y);
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
        bun.new_x = n_cur_x;
        bun.new_y = n_cur_y;
    end

    // An unused operation leaves the input register without producing anything.
    assign adv         = r_in_valid & (~op_ok | i_space);
    assign o_stall     = r_in_valid & ~adv;
    assign load        = i_valid & ~o_stall;
    assign o_bun_valid = r_in_valid & op_ok;
    assign o_bun       = bun;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cur_x    <= CURSOR_X_RST;
            r_cur_y    <= CURSOR_Y_RST;
            r_held     <= '0;
        end else begin
            if (load) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv && op_ok) begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
                r_held  <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_op      <= i_operation;
            r_buttons <= i_buttons;
            r_dx      <= i_delta_x;
            r_dy      <= i_delta_y;
            r_wheel   <= i_wheel;
            r_nx      <= i_new_x;
            r_ny      <= i_new_y;
        end
    end

endmodule

@@ sv/mpt_emit.sv @@
// Result register that plays out the button events and the final motion event of an item.
module mpt_emit #(
    parameter int P_BUTTON_COUNT = mpt_pkg::BUTTON_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_bun_valid,
    input  mpt_pkg::t_bundle     i_bun,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_event_kind,
    output logic [2:0]           o_button_number,
    output logic                 o_pressed,
    output logic [4:0]           o_held_buttons,
    output logic signed [16:0]   o_move_x,
    output logic signed [16:0]   o_move_y,
    output logic signed [7:0]    o_wheel_out,
    output logic signed [15:0]   o_pointer_x,
    output logic signed [15:0]   o_pointer_y,
    output logic                 o_last
);
    import mpt_pkg::*;

    localparam int LP_EV = (P_BUTTON_COUNT < BUTTON_BITS) ? P_BUTTON_COUNT : BUTTON_BITS;

    logic             r_valid;
    t_bundle          r_bun;
    logic [LP_EV-1:0] r_mask;

    logic [LP_EV-1:0] low;
    logic [LP_EV-1:0] n_mask;
    logic [2:0]       num;
    logic             any;
    logic             take;
    logic             done;
    logic             load;

    // Lowest pending button goes first, so events come out in ascending order.
    assign low = r_mask & (~r_mask + LP_EV'(1));
    assign any = |r_mask;

    always_comb begin
        num = '0;
        for (int i = 0; i < LP_EV; i++) begin
            if (low[i]) num = 3'(i + 1);
        end
    end

    assign take    = r_valid & ~i_stall;
    assign done    = take & ~any;
    assign o_space = ~r_valid | done;
    assign load    = i_bun_valid & o_space;

    always_comb begin
        n_mask = r_mask;
        if (load) begin
            n_mask = i_bun.changed[LP_EV-1:0];
        end else if (take) begin
            n_mask = r_mask & ~low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mask  <= '0;
        end else begin
            r_mask <= n_mask;
            if (load) begin
                r_valid <= 1'b1;
            end else if (done) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bun <= i_bun;
        end
    end

    assign o_valid         = r_valid;
    assign o_event_kind    = any ? EV_BUTTON : EV_MOTION;
    assign o_button_number = any ? num : 3'd0;
    assign o_pressed       = any & (|(low & r_bun.buttons[LP_EV-1:0]));
    assign o_held_buttons  = r_bun.buttons;
    assign o_move_x        = any ? 17'sd0 : r_bun.move_x;
    assign o_move_y        = any ? 17'sd0 : r_bun.move_y;
    assign o_wheel_out     = any ? 8'sd0 : r_bun.wheel;
    assign o_pointer_x     = any ? r_bun.old_x : r_bun.new_x;
    assign o_pointer_y     = any ? r_bun.old_y : r_bun.new_y;
    assign o_last          = ~any;

endmodule

@@ sv/mpt_checker.sv @@
// Port-level checks of the mouse pointer tracker, bound to the top level.
module mpt_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic                 o_event_kind,
    input logic [2:0]           o_button_number,
    input logic                 o_pressed,
    input logic signed [16:0]   o_move_x,
    input logic signed [16:0]   o_move_y,
    input logic signed [7:0]    o_wheel_out,
    input logic signed [15:0]   o_pointer_x,
    input logic signed [15:0]   o_pointer_y,
    input logic                 o_last
);
    import mpt_pkg::*;

    // A held result keeps its valid, its pointer, its button number and its last flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pointer_x) && $stable(o_pointer_y)
            && $stable(o_button_number) && $stable(o_last))
        else $error("result changed while stalled");

    // Button events never close an item and carry no movement.
    a_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == EV_BUTTON) |-> !o_last && (o_button_number != 3'd0)
            && (o_move_x == 17'sd0) && (o_move_y == 17'sd0) && (o_wheel_out == 8'sd0))
        else $error("malformed button event");

    // The motion event always closes an item.
    a_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == EV_MOTION) |-> o_last && (o_button_number == 3'd0)
            && !o_pressed)
        else $error("malformed motion event");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind mouse_pointer_tracker mpt_checker u_mpt_checker (.*);

@@ tb/sv/tb_mouse_pointer_tracker.sv @@
// Self-checking testbench for the mouse pointer tracker.
`timescale 1ns / 1ps

module tb_mouse_pointer_tracker;
    import mpt_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         DIRECTED_ROWS = 16;
    localparam int         ITEMS_PER_SET = 36;
    localparam int         HOLD_CYCLES   = 80;

    // One input item, optionally with the motion fields that it must give.
    typedef struct {
        logic [1:0]         op;
        logic [4:0]         btn;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [7:0]  wh;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        bit                 typed;
        logic signed [16:0] exp_mx;
        logic signed [16:0] exp_my;
        logic signed [15:0] exp_px;
        logic signed [15:0] exp_py;
    } t_stim_row;

    typedef struct {
        logic               kind;
        logic [2:0]         num;
        logic               pressed;
        logic [4:0]         state;
        logic signed [16:0] mx;
        logic signed [16:0] my;
        logic signed [7:0]  wh;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic               last;
    } t_pointer_event;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_operation;
    logic [4:0]         i_buttons;
    logic signed [15:0] i_delta_x;
    logic signed [15:0] i_delta_y;
    logic signed [7:0]  i_wheel;
    logic signed [15:0] i_new_x;
    logic signed [15:0] i_new_y;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_event_kind;
    logic [2:0]         o_button_number;
    logic               o_pressed;
    logic [4:0]         o_held_buttons;
    logic signed [16:0] o_move_x;
    logic signed [16:0] o_move_y;
    logic signed [7:0]  o_wheel_out;
    logic signed [15:0] o_pointer_x;
    logic signed [15:0] o_pointer_y;
    logic               o_last;

    // Own copy of the block's state and settings.
    t_cfg               model_cfg;
    logic signed [15:0] model_x;
    logic signed [15:0] model_y;
    logic [4:0]         model_held;

    t_pointer_event pending_pointer_events[$];
    int mismatch_count = 0;
    int hold_requests  = 0;
    int holds_granted  = 0;
    int hold_left      = 0;
    int rx_cycle       = 0;

    // Defaults first, then extremes of each field, the acceleration threshold edge,
    // clamping on every side, an unused operation and buttons held across items.
    t_stim_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{OP_REPORT,   5'h00,      0,      0,    0,      0,     0, 1,
          0, 0, 512, 384},
        '{OP_REPORT,   5'h1F,     10,    -10,  127,      0,     0, 1,
          10, -10, 522, 374},
        '{OP_REPORT,   5'h00,     11,    -11,   -1,      0,     0, 1,
          16, -16, 538, 358},
        '{OP_REPORT,   5'h00,  32767,  32767, -128,      0,     0, 1,
          49150, 49150, 1023, 767},
        '{OP_REPORT,   5'h00, -32768, -32768,    0,      0,     0, 1,
          -49152, -49152, 0, 0},
        '{OP_SET_POS,  5'h00,      0,      0,    0, -32768, 32767, 1,
          0, 0, 0, 767},
        '{OP_SET_POS,  5'h00,      0,      0,    0,    100,   200, 1,
          0, 0, 100, 200},
        '{OP_RECENTER, 5'h00,      0,      0,    0,      0,     0, 1,
          0, 0, 511, 383},
        '{OP_UNUSED,   5'h1F,      5,      5,    5,      7,     7, 0,
          0, 0, 0, 0},
        '{OP_REPORT,   5'h0A,     -3,      7,    1,      0,     0, 0,
          0, 0, 0, 0},
        '{OP_REPORT,   5'h15,    -11,     12,   -2,      0,     0, 0,
          0, 0, 0, 0},
        '{OP_REPORT,   5'h15,    -12,     13,    0,      0,     0, 0,
          0, 0, 0, 0},
        '{OP_REPORT,   5'h01,   5000,  -5000,   64,      0,     0, 0,
          0, 0, 0, 0},
        '{OP_SET_POS,  5'h1A,      0,      0,    0,   2000,    -5, 1,
          0, 0, 1023, 0},
        '{OP_RECENTER, 5'h00,      0,      0,    0,      0,     0, 1,
          0, 0, 511, 383},
        '{OP_REPORT,   5'h1E,      1,     -1,    3,      0,     0, 0,
          0, 0, 0, 0}
    };

    // accel_enable, accel_threshold, min_x, max_x, min_y, max_y
    int fixed_sets [0:2][0:5] = '{
        '{0, 32767, -32768, 32767, -32768, 32767},
        '{1, 0, -20, 20, -7, 0},
        '{1, 32767, 100, -100, 300, -300}
    };

    mouse_pointer_tracker u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_buttons       (i_buttons),
        .i_delta_x       (i_delta_x),
        .i_delta_y       (i_delta_y),
        .i_wheel         (i_wheel),
        .i_new_x         (i_new_x),
        .i_new_y         (i_new_y),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_button_number (o_button_number),
        .o_pressed       (o_pressed),
        .o_held_buttons  (o_held_buttons),
        .o_move_x        (o_move_x),
        .o_move_y        (o_move_y),
        .o_wheel_out     (o_wheel_out),
        .o_pointer_x     (o_pointer_x),
        .o_pointer_y     (o_pointer_y),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    function automatic int boosted_delta(input int d);
        int mag;
        mag = (d < 0) ? -d : d;
        if (model_cfg.accel_en && mag > int'(model_cfg.accel_thr)) begin
            return d + d / 2;
        end
        return d;
    endfunction

    function automatic int clamp_axis(input int v, input int lo, input int hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    // Updates the tracked state for one accepted item and queues its events.
    task automatic compute_pointer_events(input t_stim_row row);
        t_pointer_event ev;
        logic [4:0] flips;
        int mx, my, lo_x, hi_x, lo_y, hi_y;
        lo_x = $signed(model_cfg.min_x);
        hi_x = $signed(model_cfg.max_x);
        lo_y = $signed(model_cfg.min_y);
        hi_y = $signed(model_cfg.max_y);
        ev = '{default: '0};
        mx = 0;
        my = 0;
        if (row.op == OP_REPORT) begin
            flips = model_held ^ row.btn;
            mx = boosted_delta(row.dx);
            my = boosted_delta(row.dy);
            model_held = row.btn;
            // Button events carry the cursor from before this report's movement.
            ev.kind = EV_BUTTON;
            ev.state = model_held;
            ev.px = model_x;
            ev.py = model_y;
            for (int b = 0; b < BUTTON_BITS && b < BUTTON_COUNT_DEF; b++) begin
                if (flips[b]) begin
                    ev.num = 3'(b + 1);
                    ev.pressed = row.btn[b];
                    pending_pointer_events.push_back(ev);
                end
            end
            model_x = 16'(clamp_axis(model_x + mx, lo_x, hi_x));
            model_y = 16'(clamp_axis(model_y + my, lo_y, hi_y));
            ev.wh = row.wh;
        end else if (row.op == OP_SET_POS) begin
            model_x = 16'(clamp_axis(row.nx, lo_x, hi_x));
            model_y = 16'(clamp_axis(row.ny, lo_y, hi_y));
        end else if (row.op == OP_RECENTER) begin
            model_x = 16'((lo_x + hi_x) / 2);
            model_y = 16'((lo_y + hi_y) / 2);
        end
        if (row.op != OP_UNUSED) begin
            ev.kind = EV_MOTION;
            ev.num = 3'd0;
            ev.pressed = 1'b0;
            ev.state = model_held;
            ev.mx = 17'(mx);
            ev.my = 17'(my);
            ev.px = model_x;
            ev.py = model_y;
            ev.last = 1'b1;
            if (row.typed) begin
                ev.mx = row.exp_mx;
                ev.my = row.exp_my;
                ev.px = row.exp_px;
                ev.py = row.exp_py;
            end
            pending_pointer_events.push_back(ev);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high.
    task automatic offer_item(input t_stim_row row);
        i_valid = 1'b1;
        i_operation = row.op;
        i_buttons = row.btn;
        i_delta_x = row.dx;
        i_delta_y = row.dy;
        i_wheel = row.wh;
        i_new_x = row.nx;
        i_new_y = row.ny;
        do @(posedge i_clk); while (o_stall);
        compute_pointer_events(row);
        @(negedge i_clk);
    endtask

    task automatic program_settings(input int vals [0:5]);
        i_cfg_valid = 1'b1;
        for (int r = 0; r < 6; r++) begin
            i_cfg_index = 3'(r);
            i_cfg_data = 16'(vals[r]);
            do @(posedge i_clk); while (!o_cfg_ready);
            case (t_cfg_idx'(r))
                CFG_ACCEL_EN:  model_cfg.accel_en = i_cfg_data[0];
                CFG_ACCEL_THR: model_cfg.accel_thr = i_cfg_data[14:0];
                CFG_MIN_X:     model_cfg.min_x = i_cfg_data;
                CFG_MAX_X:     model_cfg.max_x = i_cfg_data;
                CFG_MIN_Y:     model_cfg.min_y = i_cfg_data;
                default:       model_cfg.max_y = i_cfg_data;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic signed [15:0] pick_delta();
        int m;
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 30) - 15);
            1: begin
                m = int'(model_cfg.accel_thr) + $urandom_range(0, 2) - 1;
                return 16'(($urandom_range(0, 1) == 1) ? -m : m);
            end
            2: return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_coord();
        if ($urandom_range(0, 1) == 1) return 16'($urandom);
        return 16'($urandom_range(0, 2400) - 1200);
    endfunction

    function automatic t_stim_row random_row();
        t_stim_row row;
        int p;
        row = '{default: '0};
        p = $urandom_range(0, 99);
        if (p < 70) row.op = OP_REPORT;
        else if (p < 82) row.op = OP_SET_POS;
        else if (p < 92) row.op = OP_RECENTER;
        else row.op = OP_UNUSED;
        case ($urandom_range(0, 2))
            0: row.btn = model_held;
            1: row.btn = model_held ^ (5'b00001 << $urandom_range(0, 4));
            default: row.btn = 5'($urandom);
        endcase
        row.dx = pick_delta();
        row.dy = pick_delta();
        row.wh = 8'($urandom);
        row.nx = pick_coord();
        row.ny = pick_coord();
        return row;
    endfunction

    // Receiver: rotating stall patterns, plus a long hold-off when asked.
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (holds_granted != hold_requests) begin
            holds_granted <= holds_granted + 1;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            case ((rx_cycle / 48) % 4)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 99) < 50);
                2: i_stall <= ($urandom_range(0, 99) < 15);
                default: i_stall <= ((rx_cycle % 5) < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pointer_event want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pointer_events.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending, kind %0d", o_event_kind));
            end else begin
                want = pending_pointer_events.pop_front();
                compare_field("event_kind", o_event_kind, want.kind);
                compare_field("button_number", o_button_number, want.num);
                compare_field("pressed", o_pressed, want.pressed);
                compare_field("held_buttons", o_held_buttons, want.state);
                compare_field("move_x", o_move_x, want.mx);
                compare_field("move_y", o_move_y, want.my);
                compare_field("wheel_out", o_wheel_out, want.wh);
                compare_field("pointer_x", o_pointer_x, want.px);
                compare_field("pointer_y", o_pointer_y, want.py);
                compare_field("last", o_last, want.last);
            end
        end
    end

    initial begin
        t_stim_row row;
        int vals [0:5];
        int counted;
        int burst_left;
        int w;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 3'd0;
        i_cfg_data = 16'd0;
        i_valid = 1'b0;
        i_operation = OP_REPORT;
        i_buttons = 5'd0;
        i_delta_x = 16'sd0;
        i_delta_y = 16'sd0;
        i_wheel = 8'sd0;
        i_new_x = 16'sd0;
        i_new_y = 16'sd0;
        model_cfg.accel_en = ACCEL_EN_RST;
        model_cfg.accel_thr = ACCEL_THR_RST;
        model_cfg.min_x = MIN_X_RST;
        model_cfg.max_x = MAX_X_RST;
        model_cfg.min_y = MIN_Y_RST;
        model_cfg.max_y = MAX_Y_RST;
        model_x = CURSOR_X_RST;
        model_y = CURSOR_Y_RST;
        model_held = 5'd0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            offer_item(directed_rows[r]);
        end

        for (int phase = 0; phase < 5; phase++) begin
            i_valid = 1'b0;
            // Settings change only once the block has drained.
            while (pending_pointer_events.size() != 0) @(posedge i_clk);
            repeat (6) @(posedge i_clk);
            @(negedge i_clk);
            if (phase < 3) begin
                vals = fixed_sets[phase];
            end else begin
                vals[0] = $urandom_range(0, 1);
                vals[1] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                       : $urandom_range(0, 40);
                vals[2] = $urandom_range(0, 1200) - 600;
                vals[3] = vals[2] + $urandom_range(1, 1200);
                vals[4] = $urandom_range(0, 1200) - 600;
                vals[5] = vals[4] + $urandom_range(1, 1200);
                if ($urandom_range(0, 4) == 0) vals[3] = int'($signed(16'($urandom)));
                if ($urandom_range(0, 4) == 0) vals[4] = int'($signed(16'($urandom)));
            end
            program_settings(vals);
            if (phase == 1) begin
                // The receiver holds off while items keep coming back to back.
                @(posedge i_clk);
                hold_requests++;
                @(negedge i_clk);
            end
            counted = 0;
            burst_left = $urandom_range(1, 12);
            while (counted < ITEMS_PER_SET) begin
                row = random_row();
                offer_item(row);
                if (row.op != OP_UNUSED) counted++;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    if (!(phase == 1 && counted < 24)) begin
                        i_valid = 1'b0;
                        repeat ($urandom_range(1, 6)) @(negedge i_clk);
                    end
                end
            end
        end
        i_valid = 1'b0;

        w = 0;
        while (w < 5000 && pending_pointer_events.size() != 0) begin
            @(posedge i_clk);
            w++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_pointer_events.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived",
                                    pending_pointer_events.size()));
        end
        if (mismatch_count == 0) begin
            $display("[mouse_pointer_tracker] OK");
        end else begin
            $display("[mouse_pointer_tracker] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[mouse_pointer_tracker] ERROR");
        $finish;
    end

endmodule
